// ----- design/wtoi_pkg.sv -----
// package for the wavetable oscillator: register codes, waveform codes and number formats
// also holds the quarter-wave sine generator used to build the sine table at elaboration
// no dependencies
package wtoi_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 16;
	localparam int FULL_SCALE  = 32768;
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef enum logic [1:0] {
		REG_PHASE_STEP,
		REG_WAVEFORM_SELECT,
		REG_INTERP_ENABLE,
		REG_MASTER_VOLUME
	} reg_index_t;

	typedef enum logic [1:0] {
		WAVE_SINE,
		WAVE_SAW,
		WAVE_SQUARE,
		WAVE_TRIANGLE
	} wave_t;

	// 2^30 over the divisor of the k-th series term, rounded down
	function automatic longint unsigned taylor_recip(input int k);
		case (k)
			1:       return 64'd178956970;
			2:       return 64'd53687091;
			3:       return 64'd25565281;
			4:       return 64'd14913080;
			5:       return 64'd9761289;
			6:       return 64'd6882960;
			7:       return 64'd5113056;
			8:       return 64'd3947580;
			default: return 64'd3139595;
		endcase
	endfunction

	// full scale times sin(2 pi j / 2^addr_bits), rounded and capped below full scale, for j up to a quarter
	function automatic logic [SAMPLE_BITS-1:0] quarter_sine(input int unsigned j,
			input int unsigned addr_bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned prod;
		longint unsigned den;
		longint unsigned q;
		longint sum;
		longint unsigned v;
		x = (PI_Q30 * longint'(j) * 64'd2) >> addr_bits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 9; k++) begin
			den = longint'((2 * k) * (2 * k + 1));
			prod = (term * x2) >> 30;
			// reciprocal estimate never overshoots, then step up to the exact quotient
			q = (prod * taylor_recip(k)) >> 30;
			while ((q + 64'd1) * den <= prod) begin
				q = q + 64'd1;
			end
			term = q;
			if ((k % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (longint'(sum) * longint'(FULL_SCALE) + (64'd1 << 29)) >> 30;
		if (v > longint'(FULL_SCALE - 1)) begin
			v = longint'(FULL_SCALE - 1);
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

endpackage

// ----- design/wtoi_ram.sv -----
// generic single-port-write, single-port-read memory with registered read data
// no dependencies
module wtoi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/wavetable_oscillator_interp_core.sv -----
// wavetable oscillator: phase accumulator, sine table in ram, shaped waves, interpolation, gain
// depends on wtoi_pkg and wtoi_ram
// a request goes through states S_RD2, S_INT, S_ENV and S_VOL; its result is registered in S_VOL
// a new request is accepted only in S_IDLE, after the previous one has passed the serial stages: two
// reads of the table, interpolation, envelope and volume, and the output is free for its result
// reset: async, clears control state and loads register defaults, then a fill pass
// writes the sine table; no request is accepted until it ends
module wavetable_oscillator_interp_core #(
	parameter int TABLE_SIZE = 256,
	parameter int PHASE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] envelope_level
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] audio_sample, signed
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SB        = wtoi_pkg::SAMPLE_BITS;
	localparam int FB        = wtoi_pkg::FRAC_BITS;
	localparam int ADDR_BITS = $clog2(TABLE_SIZE);

	localparam logic signed [17:0] FS_POS = 18'(wtoi_pkg::FULL_SCALE);
	localparam logic signed [17:0] FS_MAX = 18'(wtoi_pkg::FULL_SCALE - 1);

	typedef enum logic [2:0] {S_FILL, S_IDLE, S_RD2, S_INT, S_ENV, S_VOL} state_t;
	typedef logic signed [SB-1:0] sine_arr_t [TABLE_SIZE];

	function automatic sine_arr_t build_sine();
		sine_arr_t t;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (i <= TABLE_SIZE / 4) begin
				t[i] = $signed(wtoi_pkg::quarter_sine(i, ADDR_BITS));
			end else if (i <= TABLE_SIZE / 2) begin
				t[i] = $signed(wtoi_pkg::quarter_sine(TABLE_SIZE / 2 - i, ADDR_BITS));
			end else if (i <= 3 * TABLE_SIZE / 4) begin
				t[i] = -$signed(wtoi_pkg::quarter_sine(i - TABLE_SIZE / 2, ADDR_BITS));
			end else begin
				t[i] = -$signed(wtoi_pkg::quarter_sine(TABLE_SIZE - i, ADDR_BITS));
			end
		end
		return t;
	endfunction

	localparam sine_arr_t SINE_ROM = build_sine();

	function automatic logic signed [17:0] ramp(input logic [ADDR_BITS-1:0] x);
		return $signed(18'(x) << (SB + 1 - ADDR_BITS));
	endfunction

	function automatic logic signed [SB-1:0] shape(input wtoi_pkg::wave_t sel,
			input logic [ADDR_BITS-1:0] i);
		logic [ADDR_BITS-1:0] d;
		logic [ADDR_BITS-1:0] d_lo;
		logic signed [17:0] v;
		d = i - ADDR_BITS'(TABLE_SIZE / 4);
		d_lo = d;
		d_lo[ADDR_BITS-1] = 1'b0;
		case (sel)
			wtoi_pkg::WAVE_SAW: begin
				v = $signed(18'(i) << (SB - ADDR_BITS)) - FS_POS;
			end
			wtoi_pkg::WAVE_SQUARE: begin
				v = i[ADDR_BITS-1] ? -FS_POS : FS_MAX;
			end
			wtoi_pkg::WAVE_TRIANGLE: begin
				case (i[ADDR_BITS-1:ADDR_BITS-2])
					2'b00:   v = ramp(i);
					2'b11:   v = ramp(d_lo) - FS_POS;
					default: v = FS_POS - ramp(d);
				endcase
			end
			default: begin
				v = '0;
			end
		endcase
		if (v > FS_MAX) begin
			v = FS_MAX;
		end
		return v[SB-1:0];
	endfunction

	state_t                  state_q;
	logic [ADDR_BITS-1:0]    fill_q;
	logic [31:0]             step_q;
	wtoi_pkg::wave_t         wave_q;
	logic                    interp_q;
	logic [15:0]             vol_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [ADDR_BITS-1:0]    idx_q;
	logic [ADDR_BITS-1:0]    nxt_q;
	logic [FB-1:0]           frac_q;
	logic [15:0]             env_q;
	logic signed [SB-1:0]    s1_q;
	logic signed [SB-1:0]    y_q;
	logic signed [16:0]      e_q;
	logic                    out_valid_q;
	logic [15:0]             out_data_q;

	logic                    in_acc;
	logic [PHASE_BITS-1:0]   step_w;
	logic [ADDR_BITS-1:0]    idx_now;
	logic [PHASE_BITS-1:0]   ph_shl;
	logic [ADDR_BITS-1:0]    ram_raddr;
	logic [SB-1:0]           ram_rdata;
	logic                    ram_we;
	logic signed [SB-1:0]    entry;
	logic signed [16:0]      diff;
	logic signed [33:0]      interp_rnd;
	logic signed [17:0]      interp_y;
	logic signed [32:0]      env_rnd;
	logic signed [33:0]      vol_rnd;
	logic signed [18:0]      vol_y;
	logic [15:0]             sat_y;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign step_w  = PHASE_BITS'(step_q);
	assign idx_now = phase_q[PHASE_BITS-1 -: ADDR_BITS];
	assign ph_shl  = phase_q << ADDR_BITS;

	assign ram_we    = (state_q == S_FILL);
	assign ram_raddr = (state_q == S_RD2) ? nxt_q : idx_now;

	wtoi_ram #(
		.WIDTH (SB),
		.DEPTH (TABLE_SIZE)
	) u_sine_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q),
		.wdata (SINE_ROM[fill_q]),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (wave_q == wtoi_pkg::WAVE_SINE) begin
			entry = $signed(ram_rdata);
		end else begin
			entry = shape(wave_q, (state_q == S_RD2) ? idx_q : nxt_q);
		end
		diff       = 17'(entry) - 17'(s1_q);
		interp_rnd = diff * $signed({1'b0, frac_q}) + 34'sd32768;
		interp_y   = 18'(s1_q) + interp_rnd[33:16];
		env_rnd    = y_q * $signed({1'b0, env_q}) + 33'sd16384;
		vol_rnd    = e_q * $signed({1'b0, vol_q}) + 34'sd16384;
		vol_y      = vol_rnd[33:15];
		if (vol_y > 19'(FS_MAX)) begin
			sat_y = FS_MAX[15:0];
		end else if (vol_y < -19'(FS_POS)) begin
			sat_y = 16'(-FS_POS);
		end else begin
			sat_y = vol_y[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			fill_q      <= '0;
			step_q      <= '0;
			wave_q      <= wtoi_pkg::WAVE_SINE;
			interp_q    <= 1'b1;
			vol_q       <= 16'h8000;
			phase_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (wtoi_pkg::reg_index_t'(cfg_index))
					wtoi_pkg::REG_PHASE_STEP:      step_q   <= cfg_data;
					wtoi_pkg::REG_WAVEFORM_SELECT: wave_q   <= wtoi_pkg::wave_t'(cfg_data[1:0]);
					wtoi_pkg::REG_INTERP_ENABLE:   interp_q <= cfg_data[0];
					wtoi_pkg::REG_MASTER_VOLUME:   vol_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (m_axis_tready && (state_q != S_VOL)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						idx_q   <= idx_now;
						nxt_q   <= idx_now + 1'b1;
						frac_q  <= ph_shl[PHASE_BITS-1 -: FB];
						env_q   <= s_axis_tdata;
						phase_q <= phase_q + step_w;
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					s1_q    <= entry;
					state_q <= S_INT;
				end
				S_INT: begin
					y_q     <= interp_q ? interp_y[SB-1:0] : s1_q;
					state_q <= S_ENV;
				end
				S_ENV: begin
					e_q     <= env_rnd[31:15];
					state_q <= S_VOL;
				end
				S_VOL: begin
					if (!out_valid_q || m_axis_tready) begin
						out_data_q  <= sat_y;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !s_axis_tready)
		else $error("request accepted while previous one in flight");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (phase_q == $past(phase_q + step_w)))
		else $error("phase did not advance by one step");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(phase_q))
		else $error("phase moved without a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_VOL))
		else $error("result raised outside the gain stage");
`endif

endmodule
